@@ src/positional_list_store_top_defines.svh @@
// Assertion macros for the positional list store.
// Used by positional_list_store_top; expects clk and rst_n in scope.
`ifndef POSITIONAL_LIST_STORE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_STORE_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/plc_pkg.sv @@
// Shared types and constants of the positional list store.
// No dependencies; used by the interfaces, the cell and the top level.
package plc_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ACT_W        = 3;
    localparam int POS_W        = 8;
    localparam int VAL_W        = 32;
    localparam int LEN_W        = 6;
    localparam int GRP_SIZE     = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_GET    = 3'd2,
        ACT_SET    = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GATHER
    } state_t;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             set;
        logic [POS_W-1:0] pidx;
        logic [VAL_W-1:0] value;
    } plc_cmd_t;

endpackage

@@ src/plc_req_if.sv @@
// Request channel of the positional list store.
// Depends on plc_pkg for field widths.
interface plc_req_if;
    import plc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, action, position, value, input ready);
    modport sink   (input valid, action, position, value, output ready);
endinterface

@@ src/plc_res_if.sv @@
// Result channel of the positional list store.
// Depends on plc_pkg for field widths.
interface plc_res_if;
    import plc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
    logic                    empty_res;

    modport source (output valid, ok, read_value, length, empty_res, input ready);
    modport sink   (input valid, ok, read_value, length, empty_res, output ready);
endinterface

@@ src/plc_cell.sv @@
// One list cell: holds one entry and takes a neighbor's entry on shifts.
// Depends on plc_pkg for the command struct.
module plc_cell #(
    parameter int IDX = 0
) (
    input  logic                         clk,
    input  plc_pkg::plc_cmd_t            cmd,
    input  logic [plc_pkg::VAL_W-1:0]    left,
    input  logic [plc_pkg::VAL_W-1:0]    right,
    output logic [plc_pkg::VAL_W-1:0]    entry,
    output logic [plc_pkg::VAL_W-1:0]    rd
);
    import plc_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (cmd.pidx == MY_IDX)
                entry_next = cmd.value;
            else if (cmd.pidx < MY_IDX)
                entry_next = left;
        end
        else if (cmd.rem)
        begin
            if (cmd.pidx <= MY_IDX)
                entry_next = right;
        end
        else if (cmd.set && (cmd.pidx == MY_IDX))
        begin
            entry_next = cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign rd    = (cmd.pidx == MY_IDX) ? entry_reg : '0;

endmodule

@@ src/positional_list_store_top.sv @@
// Top level of the positional list store: control, cell chain, read fold.
// Depends on plc_pkg, plc_req_if, plc_res_if, plc_cell and the defines header.
//
// An ordered list of up to CAPACITY signed 32-bit entries addressed by 1-based
// position, held in a row of cells that shift in parallel on insert and
// remove. A transaction runs through the execute and gather states after the
// edge that accepts it: in execute the cells update and the selected entry is
// ORed within groups of 16 cells, in gather the group words fold into the
// output register. A new request is taken only once the previous one has
// reached the output register, so the block does not take a new transaction
// while one is in execute or gather. A result may wait at the output while the
// next request is accepted and executed; while it stays unread the next one
// holds in the fold cycle. Entries need no clearing after reset.
`include "positional_list_store_top_defines.svh"

module positional_list_store_top #(
    parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    plc_req_if.sink   req,
    plc_res_if.source res
);
    import plc_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    state_t state_reg, state_next;

    logic [ACT_W-1:0] act_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;

    logic [CNT_W-1:0] count_reg, count_next;

    logic             ok_reg, ok_next;
    logic             hit_reg, hit_next;
    logic [LEN_W-1:0] len_reg;
    logic             empty_reg;
    logic [VAL_W-1:0] grp_reg  [NGRP];
    logic [VAL_W-1:0] grp_next [NGRP];

    logic             out_valid_reg;
    logic             out_ok_reg;
    logic [VAL_W-1:0] out_rd_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_empty_reg;

    logic [VAL_W-1:0] entry [CAPACITY];
    logic [VAL_W-1:0] rd    [CAPACITY];
    logic [VAL_W-1:0] rd_grp [NGRP][GRP_SIZE];
    logic [VAL_W-1:0] rd_all;

    plc_cmd_t cmd;

    logic             accept;
    logic             load_out;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             in_range;
    logic             ins_ok;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_GATHER) && (!out_valid_reg || res.ready);

    assign pos_x    = CMP_W'(pos_reg);
    assign cnt_x    = CMP_W'(count_reg);
    assign in_range = (pos_reg != '0) && (pos_x <= cnt_x);
    assign ins_ok   = (pos_reg != '0) && (pos_x <= cnt_x + CMP_W'(1))
                      && (cnt_x < CMP_W'(CAPACITY));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ok_next    = 1'b0;
        hit_next   = 1'b0;
        cmd        = '0;
        cmd.pidx   = pos_reg - POS_W'(1);
        cmd.value  = val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_GATHER;
                case (action_t'(act_reg))
                    ACT_INSERT:
                    begin
                        if (ins_ok)
                        begin
                            cmd.ins    = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (in_range)
                        begin
                            cmd.rem    = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    ACT_GET:
                    begin
                        ok_next  = in_range;
                        hit_next = in_range;
                    end
                    ACT_SET:
                    begin
                        if (in_range)
                        begin
                            cmd.set = 1'b1;
                            ok_next = 1'b1;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        count_next = '0;
                        ok_next    = 1'b1;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_GATHER:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= req.action;
            pos_reg <= req.position;
            val_reg <= req.value;
        end
        if (state_reg == ST_EXEC)
        begin
            ok_reg    <= ok_next;
            hit_reg   <= hit_next;
            len_reg   <= LEN_W'(count_next);
            empty_reg <= (count_next == '0);
            for (int g = 0; g < NGRP; g++)
                grp_reg[g] <= grp_next[g];
        end
        if (load_out)
        begin
            out_ok_reg    <= ok_reg;
            out_rd_reg    <= hit_reg ? rd_all : '0;
            out_len_reg   <= len_reg;
            out_empty_reg <= empty_reg;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_w;
        logic [VAL_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entry[i+1];
        end

        plc_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .left  (left_w),
            .right (right_w),
            .entry (entry[i]),
            .rd    (rd[i])
        );
    end

    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        for (genvar k = 0; k < GRP_SIZE; k++)
        begin : g_slot
            if (g * GRP_SIZE + k < CAPACITY)
            begin : g_used
                assign rd_grp[g][k] = rd[g * GRP_SIZE + k];
            end
            else
            begin : g_pad
                assign rd_grp[g][k] = '0;
            end
        end

        always_comb
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
                grp_next[g] = grp_next[g] | rd_grp[g][k];
        end
    end

    always_comb
    begin
        rd_all = '0;
        for (int g = 0; g < NGRP; g++)
            rd_all = rd_all | grp_reg[g];
    end

    assign res.valid      = out_valid_reg;
    assign res.ok         = out_ok_reg;
    assign res.read_value = out_rd_reg;
    assign res.length     = out_len_reg;
    assign res.empty_res  = out_empty_reg;

    `PLC_ASSERT_ALWAYS(a_count_bound, (!rst_n || (count_reg <= CNT_W'(CAPACITY))), "count exceeds capacity")
    `PLC_ASSERT(a_accept_exec, (accept |=> (state_reg == ST_EXEC)), "accepted request not executed")
    `PLC_ASSERT(a_exec_gather, ((state_reg == ST_EXEC) |=> (state_reg == ST_GATHER)), "exec not followed by gather")
    `PLC_ASSERT(a_result_src, ($rose(out_valid_reg) |-> ($past(state_reg) == ST_GATHER)), "result without gather")

endmodule
